// ----- src/modular_square_root_unit_macros.svh -----
// ---------------------------------------------------------------------------
// modular square root unit assertion macros
// checks compile in simulation and drop out of synthesis
// ---------------------------------------------------------------------------
`ifndef MODULAR_SQUARE_ROOT_UNIT_MACROS_SVH
`define MODULAR_SQUARE_ROOT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("modular square root unit check failed");
// next-cycle implication
`define MSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("modular square root unit check failed");
`else
`define MSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/msr_pkg.sv -----
// ---------------------------------------------------------------------------
// msr_pkg
// shared types, codes and constants of the modular square root unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package msr_pkg;

	// result status codes
	localparam logic [1:0] ST_FOUND  = 2'd0;
	localparam logic [1:0] ST_NONRES = 2'd1;
	localparam logic [1:0] ST_FAIL   = 2'd2;

	// cap on the non-residue search
	localparam logic [31:0] NONRES_LIMIT = 32'd1024;

	// datapath operations
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_HALVE,
		OP_POW_INIT,
		OP_ESHIFT,
		OP_MUL,
		OP_COPY,
		OP_Z_INIT,
		OP_Z_INC,
		OP_M_INIT,
		OP_ORD_INIT,
		OP_I_INC,
		OP_B_INIT,
		OP_J_INC,
		OP_M_SET
	} dp_op_t;

	// operand and destination registers
	typedef enum logic [3:0] {
		SEL_ONE,
		SEL_ACC,
		SEL_BASE,
		SEL_TMP,
		SEL_B,
		SEL_C,
		SEL_T,
		SEL_R,
		SEL_N,
		SEL_Z
	} sel_t;

	// exponent sources
	typedef enum logic [1:0] {
		EXP_HALF,
		EXP_QTR,
		EXP_Q,
		EXP_QH
	} exp_t;

	// root sources
	typedef enum logic [1:0] {
		ROOT_ZERO,
		ROOT_BIT,
		ROOT_ACC,
		ROOT_R
	} root_sel_t;

	typedef struct packed {
		dp_op_t    op;
		sel_t      x_sel;
		sel_t      y_sel;
		sel_t      d_sel;
		exp_t      e_sel;
		root_sel_t root_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic p_lt2;
		logic p_is2;
		logic p_even;
		logic n_zero;
		logic acc_one;
		logic acc_pm1;
		logic q_even;
		logic s_one;
		logic z_bad;
		logic e_zero;
		logic e_odd;
		logic t_zero;
		logic t_one;
		logic ord_go;
		logic i_ge_m;
		logic bsq_go;
		logic mul_done;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_POW_RED,
		S_POW_TEST,
		S_POW_SQ,
		S_POW_SHIFT,
		S_MUL_WAIT,
		S_EULER,
		S_QLOOP,
		S_SPLIT,
		S_ZTEST,
		S_ZCHK,
		S_C_INIT,
		S_C_CPY,
		S_T_INIT,
		S_T_CPY,
		S_R_INIT,
		S_R_CPY,
		S_LOOP,
		S_ORD,
		S_ORD_INC,
		S_BSQ,
		S_BSQ_INC,
		S_UPD_C,
		S_UPD_T,
		S_UPD_R,
		S_DONE
	} state_t;

endpackage

// ----- src/msr_dp.sv -----
// ---------------------------------------------------------------------------
// msr_dp
// register set, bit-serial modular multiplier and status flags
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msr_dp import msr_pkg::*; #(
	parameter int W = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   value,
	input  logic [31:0]   modulus,
	input  dp_cmd_t       cmd,
	output dp_stat_t      stat,
	output logic [W-1:0]  root_val
);

	localparam int CW = $clog2(W + 1);
	localparam int MW = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0]  n_q, p_q, q_q, z_q, e_q;
	logic [W-1:0]  acc_q, base_q, tmp_q, b_q, c_q, t_q, r_q;
	logic [CW-1:0] s_q, m_q, i_q, j_q;

	logic [W-1:0]  mx_q, my_q, mp_q;
	logic [MW-1:0] mcnt_q;
	logic          mbusy_q;
	sel_t          md_q;

	logic [W-1:0]  x_val, y_val, exp_val, mp_next;
	logic [W:0]    dbl, red1, sum, pw, q_inc, p_inc;
	logic          mul_done;

	// operand read ports
	function automatic logic [W-1:0] rd(input sel_t sel, input logic [W-1:0] acc,
			input logic [W-1:0] base, input logic [W-1:0] tmp, input logic [W-1:0] b,
			input logic [W-1:0] c, input logic [W-1:0] t, input logic [W-1:0] r,
			input logic [W-1:0] n, input logic [W-1:0] z);
		logic [W-1:0] v;
		case (sel)
			SEL_ONE:  v = W'(1);
			SEL_ACC:  v = acc;
			SEL_BASE: v = base;
			SEL_TMP:  v = tmp;
			SEL_B:    v = b;
			SEL_C:    v = c;
			SEL_T:    v = t;
			SEL_R:    v = r;
			SEL_N:    v = n;
			SEL_Z:    v = z;
			default:  v = '0;
		endcase
		return v;
	endfunction

	assign x_val = rd(cmd.x_sel, acc_q, base_q, tmp_q, b_q, c_q, t_q, r_q, n_q, z_q);
	assign y_val = rd(cmd.y_sel, acc_q, base_q, tmp_q, b_q, c_q, t_q, r_q, n_q, z_q);

	// exponent selection
	assign p_inc = {1'b0, p_q} + (W+1)'(1);
	assign q_inc = {1'b0, q_q} + (W+1)'(1);
	always_comb begin
		case (cmd.e_sel)
			EXP_HALF: exp_val = p_q >> 1;
			EXP_QTR:  exp_val = W'(p_inc >> 2);
			EXP_Q:    exp_val = q_q;
			EXP_QH:   exp_val = W'(q_inc >> 1);
			default:  exp_val = '0;
		endcase
	end

	// one multiplier bit per cycle: double, reduce, add, reduce
	assign pw      = {1'b0, p_q};
	assign dbl     = {mp_q, 1'b0};
	assign red1    = (dbl >= pw) ? dbl - pw : dbl;
	assign sum     = red1 + (my_q[W-1] ? {1'b0, mx_q} : '0);
	assign mp_next = (sum >= pw) ? W'(sum - pw) : W'(sum);
	assign mul_done = mbusy_q && (mcnt_q == '0);

	// multiplier control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
		end else if (cmd.op == OP_MUL) begin
			mbusy_q <= 1'b1;
		end else if (mul_done) begin
			mbusy_q <= 1'b0;
		end
	end

	// multiplier operands
	always_ff @(posedge clk) begin
		if (cmd.op == OP_MUL) begin
			mx_q   <= x_val;
			my_q   <= y_val;
			mp_q   <= '0;
			mcnt_q <= MW'(W - 1);
			md_q   <= cmd.d_sel;
		end else if (mbusy_q) begin
			mx_q   <= mx_q;
			my_q   <= my_q << 1;
			mp_q   <= mp_next;
			mcnt_q <= mcnt_q - MW'(1);
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (mul_done) begin
			case (md_q)
				SEL_ACC:  acc_q  <= mp_next;
				SEL_BASE: base_q <= mp_next;
				SEL_TMP:  tmp_q  <= mp_next;
				SEL_B:    b_q    <= mp_next;
				SEL_C:    c_q    <= mp_next;
				SEL_T:    t_q    <= mp_next;
				SEL_R:    r_q    <= mp_next;
				default:  acc_q  <= acc_q;
			endcase
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					n_q <= value[W-1:0];
					p_q <= modulus[W-1:0];
					q_q <= modulus[W-1:0] - W'(1);
					s_q <= '0;
				end
				OP_HALVE: begin
					q_q <= q_q >> 1;
					s_q <= s_q + CW'(1);
				end
				OP_POW_INIT: begin
					acc_q  <= W'(1);
					base_q <= x_val;
					e_q    <= exp_val;
				end
				OP_ESHIFT:   e_q <= e_q >> 1;
				OP_COPY: begin
					case (cmd.d_sel)
						SEL_C:   c_q <= acc_q;
						SEL_T:   t_q <= acc_q;
						SEL_R:   r_q <= acc_q;
						default: c_q <= c_q;
					endcase
				end
				OP_Z_INIT:   z_q <= W'(2);
				OP_Z_INC:    z_q <= z_q + W'(1);
				OP_M_INIT:   m_q <= s_q;
				OP_ORD_INIT: begin
					tmp_q <= t_q;
					i_q   <= '0;
				end
				OP_I_INC:    i_q <= i_q + CW'(1);
				OP_B_INIT: begin
					b_q <= c_q;
					j_q <= '0;
				end
				OP_J_INC:    j_q <= j_q + CW'(1);
				OP_M_SET:    m_q <= i_q;
				default:     e_q <= e_q;
			endcase
		end
	end

	// status flags
	always_comb begin
		stat.p_lt2    = p_q < W'(2);
		stat.p_is2    = p_q == W'(2);
		stat.p_even   = !p_q[0];
		stat.n_zero   = n_q == '0;
		stat.acc_one  = acc_q == W'(1);
		stat.acc_pm1  = acc_q == (p_q - W'(1));
		stat.q_even   = !q_q[0];
		stat.s_one    = s_q == CW'(1);
		stat.z_bad    = (z_q >= p_q) || (32'(z_q) > NONRES_LIMIT);
		stat.e_zero   = e_q == '0;
		stat.e_odd    = e_q[0];
		stat.t_zero   = t_q == '0;
		stat.t_one    = t_q == W'(1);
		stat.ord_go   = (tmp_q != W'(1)) && (i_q < m_q);
		stat.i_ge_m   = i_q >= m_q;
		stat.bsq_go   = ({1'b0, j_q} + {1'b0, i_q} + (CW+1)'(1)) < {1'b0, m_q};
		stat.mul_done = mul_done;
	end

	// result selection
	always_comb begin
		case (cmd.root_sel)
			ROOT_ZERO: root_val = '0;
			ROOT_BIT:  root_val = W'(n_q[0]);
			ROOT_ACC:  root_val = acc_q;
			ROOT_R:    root_val = r_q;
			default:   root_val = '0;
		endcase
	end

endmodule

// ----- src/msr_ctrl.sv -----
// ---------------------------------------------------------------------------
// msr_ctrl
// sequencer for euler test, exponentiation and tonelli-shanks loops
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msr_ctrl import msr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       out_busy,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd,
	output logic       fin,
	output logic [1:0] fin_status
);

	state_t      state_q, state_d, ret_q, ret_d, mret_q, mret_d;
	logic [1:0]  st_q, st_d;
	root_sel_t   rsel_q, rsel_d;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			mret_q  <= S_IDLE;
			st_q    <= ST_FOUND;
			rsel_q  <= ROOT_ZERO;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			mret_q  <= mret_d;
			st_q    <= st_d;
			rsel_q  <= rsel_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		mret_d  = mret_q;
		st_d    = st_q;
		rsel_d  = rsel_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_CHECK;
			S_CHECK: begin
				if (stat.p_lt2 || (stat.p_even && !stat.p_is2)) begin
					state_d = S_DONE; st_d = ST_FAIL; rsel_d = ROOT_ZERO;
				end else if (stat.p_is2) begin
					state_d = S_DONE; st_d = ST_FOUND; rsel_d = ROOT_BIT;
				end else if (stat.n_zero) begin
					state_d = S_DONE; st_d = ST_FOUND; rsel_d = ROOT_ZERO;
				end else begin
					state_d = S_POW_RED; ret_d = S_EULER;
				end
			end
			S_POW_RED: begin
				state_d = S_MUL_WAIT; mret_d = S_POW_TEST;
			end
			S_POW_TEST: begin
				if (stat.e_zero) begin
					state_d = ret_q;
				end else if (stat.e_odd) begin
					state_d = S_MUL_WAIT; mret_d = S_POW_SQ;
				end else begin
					state_d = S_POW_SQ;
				end
			end
			S_POW_SQ: begin
				state_d = S_MUL_WAIT; mret_d = S_POW_SHIFT;
			end
			S_POW_SHIFT: state_d = S_POW_TEST;
			S_MUL_WAIT: if (stat.mul_done) state_d = mret_q;
			S_EULER: begin
				if (stat.acc_one) begin
					state_d = S_QLOOP;
				end else begin
					state_d = S_DONE; st_d = ST_NONRES; rsel_d = ROOT_ZERO;
				end
			end
			S_QLOOP: if (!stat.q_even) state_d = S_SPLIT;
			S_SPLIT: begin
				if (stat.s_one) begin
					state_d = S_POW_RED; ret_d = S_DONE;
					st_d = ST_FOUND; rsel_d = ROOT_ACC;
				end else begin
					state_d = S_ZTEST;
				end
			end
			S_ZTEST: begin
				if (stat.z_bad) begin
					state_d = S_DONE; st_d = ST_FAIL; rsel_d = ROOT_ZERO;
				end else begin
					state_d = S_POW_RED; ret_d = S_ZCHK;
				end
			end
			S_ZCHK:   state_d = stat.acc_pm1 ? S_C_INIT : S_ZTEST;
			S_C_INIT: begin state_d = S_POW_RED; ret_d = S_C_CPY; end
			S_C_CPY:  state_d = S_T_INIT;
			S_T_INIT: begin state_d = S_POW_RED; ret_d = S_T_CPY; end
			S_T_CPY:  state_d = S_R_INIT;
			S_R_INIT: begin state_d = S_POW_RED; ret_d = S_R_CPY; end
			S_R_CPY:  state_d = S_LOOP;
			S_LOOP: begin
				if (stat.t_zero) begin
					state_d = S_DONE; st_d = ST_FAIL; rsel_d = ROOT_ZERO;
				end else if (stat.t_one) begin
					state_d = S_DONE; st_d = ST_FOUND; rsel_d = ROOT_R;
				end else begin
					state_d = S_ORD;
				end
			end
			S_ORD: begin
				if (stat.ord_go) begin
					state_d = S_MUL_WAIT; mret_d = S_ORD_INC;
				end else if (stat.i_ge_m) begin
					state_d = S_DONE; st_d = ST_FAIL; rsel_d = ROOT_ZERO;
				end else begin
					state_d = S_BSQ;
				end
			end
			S_ORD_INC: state_d = S_ORD;
			S_BSQ: begin
				if (stat.bsq_go) begin
					state_d = S_MUL_WAIT; mret_d = S_BSQ_INC;
				end else begin
					state_d = S_UPD_C;
				end
			end
			S_BSQ_INC: state_d = S_BSQ;
			S_UPD_C: begin state_d = S_MUL_WAIT; mret_d = S_UPD_T; end
			S_UPD_T: begin state_d = S_MUL_WAIT; mret_d = S_UPD_R; end
			S_UPD_R: begin state_d = S_MUL_WAIT; mret_d = S_LOOP; end
			S_DONE: if (!out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and datapath commands
	always_comb begin
		cmd.op       = OP_IDLE;
		cmd.x_sel    = SEL_ONE;
		cmd.y_sel    = SEL_ONE;
		cmd.d_sel    = SEL_ACC;
		cmd.e_sel    = EXP_HALF;
		cmd.root_sel = rsel_q;
		in_ready     = 1'b0;
		fin          = 1'b0;
		fin_status   = st_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_CHECK: begin
				cmd.op = (stat.p_lt2 || stat.p_even || stat.n_zero) ? OP_IDLE : OP_POW_INIT;
				cmd.x_sel = SEL_N; cmd.e_sel = EXP_HALF;
			end
			S_POW_RED: begin
				cmd.op = OP_MUL; cmd.x_sel = SEL_ONE; cmd.y_sel = SEL_BASE;
				cmd.d_sel = SEL_BASE;
			end
			S_POW_TEST: begin
				if (!stat.e_zero && stat.e_odd) begin
					cmd.op = OP_MUL; cmd.x_sel = SEL_ACC; cmd.y_sel = SEL_BASE;
					cmd.d_sel = SEL_ACC;
				end
			end
			S_POW_SQ: begin
				cmd.op = OP_MUL; cmd.x_sel = SEL_BASE; cmd.y_sel = SEL_BASE;
				cmd.d_sel = SEL_BASE;
			end
			S_POW_SHIFT: cmd.op = OP_ESHIFT;
			S_QLOOP: if (stat.q_even) cmd.op = OP_HALVE;
			S_SPLIT: begin
				cmd.op = stat.s_one ? OP_POW_INIT : OP_Z_INIT;
				cmd.x_sel = SEL_N; cmd.e_sel = EXP_QTR;
			end
			S_ZTEST: begin
				if (!stat.z_bad) cmd.op = OP_POW_INIT;
				cmd.x_sel = SEL_Z; cmd.e_sel = EXP_HALF;
			end
			S_ZCHK: cmd.op = stat.acc_pm1 ? OP_M_INIT : OP_Z_INC;
			S_C_INIT: begin
				cmd.op = OP_POW_INIT; cmd.x_sel = SEL_Z; cmd.e_sel = EXP_Q;
			end
			S_C_CPY: begin cmd.op = OP_COPY; cmd.d_sel = SEL_C; end
			S_T_INIT: begin
				cmd.op = OP_POW_INIT; cmd.x_sel = SEL_N; cmd.e_sel = EXP_Q;
			end
			S_T_CPY: begin cmd.op = OP_COPY; cmd.d_sel = SEL_T; end
			S_R_INIT: begin
				cmd.op = OP_POW_INIT; cmd.x_sel = SEL_N; cmd.e_sel = EXP_QH;
			end
			S_R_CPY: begin cmd.op = OP_COPY; cmd.d_sel = SEL_R; end
			S_LOOP: if (!stat.t_zero && !stat.t_one) cmd.op = OP_ORD_INIT;
			S_ORD: begin
				if (stat.ord_go) begin
					cmd.op = OP_MUL; cmd.x_sel = SEL_TMP; cmd.y_sel = SEL_TMP;
					cmd.d_sel = SEL_TMP;
				end else if (!stat.i_ge_m) begin
					cmd.op = OP_B_INIT;
				end
			end
			S_ORD_INC: cmd.op = OP_I_INC;
			S_BSQ: begin
				if (stat.bsq_go) begin
					cmd.op = OP_MUL; cmd.x_sel = SEL_B; cmd.y_sel = SEL_B;
					cmd.d_sel = SEL_B;
				end else begin
					cmd.op = OP_M_SET;
				end
			end
			S_BSQ_INC: cmd.op = OP_J_INC;
			S_UPD_C: begin
				cmd.op = OP_MUL; cmd.x_sel = SEL_B; cmd.y_sel = SEL_B; cmd.d_sel = SEL_C;
			end
			S_UPD_T: begin
				cmd.op = OP_MUL; cmd.x_sel = SEL_T; cmd.y_sel = SEL_C; cmd.d_sel = SEL_T;
			end
			S_UPD_R: begin
				cmd.op = OP_MUL; cmd.x_sel = SEL_R; cmd.y_sel = SEL_B; cmd.d_sel = SEL_R;
			end
			S_DONE: fin = !out_busy;
			default: cmd.op = OP_IDLE;
		endcase
	end

endmodule

// ----- src/modular_square_root_unit.sv -----
// Modular square root unit: takes a value n and a modulus p (two or an odd
// prime) and returns r with r*r = n mod p plus a status (found, not a residue,
// failure). One item is worked at a time. Every modular product runs through
// one shift-add multiplier that retires one multiplier bit per cycle; an
// exponentiation costs up to 2*(VALUE_BITS-1) products plus a reduction of the
// base, and each exponent bit adds a shift step. Trivial moduli and a zero
// value finish without an exponentiation, the Euler test is one
// exponentiation, and primes p = 1 mod 4 add one exponentiation per
// non-residue candidate and the squaring loops of Tonelli-Shanks. The next
// item is taken once the previous result sits in the output register.
// ---------------------------------------------------------------------------
// modular_square_root_unit
// top level: controller, datapath and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modular_square_root_unit_macros.svh"

module modular_square_root_unit import msr_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value,
	input  logic [31:0] modulus,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] root,
	output logic [1:0]  status
);

	dp_cmd_t               cmd;
	dp_stat_t              stat;
	logic [VALUE_BITS-1:0] root_val;
	logic                  fin, out_busy, out_valid_q;
	logic [1:0]            fin_status, status_q;
	logic [31:0]           root_q;

	assign out_busy = out_valid_q && !out_ready;

	msr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_busy   (out_busy),
		.stat       (stat),
		.cmd        (cmd),
		.fin        (fin),
		.fin_status (fin_status)
	);

	msr_dp #(.W(VALUE_BITS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.value    (value),
		.modulus  (modulus),
		.cmd      (cmd),
		.stat     (stat),
		.root_val (root_val)
	);

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (fin) begin
			root_q   <= 32'(root_val);
			status_q <= fin_status;
		end
	end

	assign out_valid = out_valid_q;
	assign root      = root_q;
	assign status    = status_q;

	// checks
	`MSR_ASSERT_IMP(a_status_code, clk, arst_n, out_valid_q,
		(status_q == ST_FOUND) || (status_q == ST_NONRES) || (status_q == ST_FAIL))
	`MSR_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`MSR_ASSERT_IMP(a_no_overwrite, clk, arst_n, fin, !out_busy)
	`MSR_ASSERT_NXT(a_fin_shows, clk, arst_n, fin, out_valid_q)

endmodule
